/* sv/nearest_center_assign_assert.svh */
// Assertion macros for the nearest-center block checkers.
// Included by the checker file; defines nothing else.
`ifndef NEAREST_CENTER_ASSIGN_ASSERT_SVH
`define NEAREST_CENTER_ASSIGN_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("nearest_center_assign: assertion failed");

// next-cycle implication, disabled during reset
`define NCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("nearest_center_assign: assertion failed");

`endif

/* sv/nca_pkg.sv */
// Shared types and constants for the nearest-center assignment block.
// No dependencies; imported by every module of the block.
package nca_pkg;

    localparam int DEF_MAX_CENTERS = 16;
    localparam int DEF_COORD_BITS  = 16;

    localparam int XY_W       = 16;
    localparam int SLOT_W     = 4;
    localparam int CFG_W      = 5;
    localparam int DIST_OUT_W = 33;

    localparam logic [DIST_OUT_W-1:0] DIST_MAX = {DIST_OUT_W{1'b1}};

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] slot;
        logic [XY_W-1:0]   coord_x;
        logic [XY_W-1:0]   coord_y;
    } t_req;

    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     nearest_slot;
        logic [DIST_OUT_W-1:0] nearest_dist_sq;
    } t_res;

    // control that travels along the cell chain with each request
    typedef struct packed {
        logic              valid;
        logic              is_cls;
        logic [SLOT_W-1:0] slot;
    } t_ctl;

endpackage

/* sv/nearest_center_assign.sv */
// Top level of the 2D k-means assignment step: chain of center cells.
// Depends on nca_pkg and nca_cell.
//
//  port group          dir  handshake            payload
//  start / busy        in   start && !busy       i_req (t_req)
//  o_strobe            out  one-cycle strobe     o_result (t_res)
//  i_cfg_we            in   write when high      i_cfg_data (centers in use)
//
// One request enters per cycle while busy is low; each result leaves after
// the two register stages in every cell and the output register.
// Loads travel the chain too and update their cell in request order.
// busy is high during reset and drops once r_ready is registered after it.
// No stall: results are shown for one cycle and are never held.
module nearest_center_assign #(
    parameter int MAX_CENTERS = nca_pkg::DEF_MAX_CENTERS,
    parameter int COORD_BITS  = nca_pkg::DEF_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  nca_pkg::t_req             i_req,
    input  logic                      i_cfg_we,
    input  logic [nca_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_strobe,
    output nca_pkg::t_res             o_result
);
    import nca_pkg::*;

    localparam int IDX_W  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DIST_W = 2 * COORD_BITS + 1;
    localparam int WIDE_W = (DIST_W > DIST_OUT_W) ? DIST_W : DIST_OUT_W;

    logic [CFG_W-1:0] r_centers_in_use;
    logic [CFG_W-1:0] active;
    logic             r_ready;
    logic             accept;
    logic             r_strobe;
    t_res             r_result, n_result;
    logic [WIDE_W-1:0] wide_d;

    t_ctl                  w_ctl  [0:MAX_CENTERS];
    logic [COORD_BITS-1:0] w_px   [0:MAX_CENTERS];
    logic [COORD_BITS-1:0] w_py   [0:MAX_CENTERS];
    logic [IDX_W-1:0]      w_bidx [0:MAX_CENTERS];
    logic [DIST_W-1:0]     w_bd   [0:MAX_CENTERS];

    assign busy   = !r_ready;
    assign accept = start && r_ready;

    always_comb begin
        active = r_centers_in_use;
        if (r_centers_in_use == '0) begin
            active = CFG_W'(1);
        end else if (32'(r_centers_in_use) > MAX_CENTERS) begin
            active = CFG_W'(MAX_CENTERS);
        end
    end

    assign w_ctl[0]  = '{valid: accept, is_cls: (i_req.req_type == REQ_CLASSIFY),
                         slot: i_req.slot};
    assign w_px[0]   = COORD_BITS'(i_req.coord_x);
    assign w_py[0]   = COORD_BITS'(i_req.coord_y);
    assign w_bidx[0] = '0;
    assign w_bd[0]   = '0;

    for (genvar k = 0; k < MAX_CENTERS; k++) begin : g_cell
        nca_cell #(
            .K          (k),
            .COORD_BITS (COORD_BITS),
            .IDX_W      (IDX_W),
            .DIST_W     (DIST_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_active   (active),
            .i_ctl      (w_ctl[k]),
            .i_px       (w_px[k]),
            .i_py       (w_py[k]),
            .i_best_idx (w_bidx[k]),
            .i_best_d   (w_bd[k]),
            .o_ctl      (w_ctl[k+1]),
            .o_px       (w_px[k+1]),
            .o_py       (w_py[k+1]),
            .o_best_idx (w_bidx[k+1]),
            .o_best_d   (w_bd[k+1])
        );
    end

    assign wide_d = WIDE_W'(w_bd[MAX_CENTERS]);

    always_comb begin
        n_result = '0;
        if (w_ctl[MAX_CENTERS].is_cls) begin
            n_result.found        = 1'b1;
            n_result.nearest_slot = SLOT_W'(w_bidx[MAX_CENTERS]);
            n_result.nearest_dist_sq = (wide_d > WIDE_W'(DIST_MAX)) ? DIST_MAX
                                                                    : wide_d[DIST_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centers_in_use <= CFG_W'(1);
            r_ready          <= 1'b0;
            r_strobe         <= 1'b0;
        end else begin
            r_ready  <= 1'b1;
            r_strobe <= w_ctl[MAX_CENTERS].valid;
            if (i_cfg_we) begin
                r_centers_in_use <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* sv/nca_cell.sv */
// One cell of the center chain: holds one center, loads it, and folds its
// distance into the running best. Depends on nca_pkg.
module nca_cell #(
    parameter int K          = 0,
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 4,
    parameter int DIST_W     = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [nca_pkg::CFG_W-1:0]  i_active,
    input  nca_pkg::t_ctl              i_ctl,
    input  logic [COORD_BITS-1:0]      i_px,
    input  logic [COORD_BITS-1:0]      i_py,
    input  logic [IDX_W-1:0]           i_best_idx,
    input  logic [DIST_W-1:0]          i_best_d,
    output nca_pkg::t_ctl              o_ctl,
    output logic [COORD_BITS-1:0]      o_px,
    output logic [COORD_BITS-1:0]      o_py,
    output logic [IDX_W-1:0]           o_best_idx,
    output logic [DIST_W-1:0]          o_best_d
);
    import nca_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS;

    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  load_hit;

    // stage 1: squared differences
    t_ctl                  r_s1_ctl;
    logic [COORD_BITS-1:0] r_s1_px, r_s1_py;
    logic [IDX_W-1:0]      r_s1_bidx;
    logic [DIST_W-1:0]     r_s1_bd;
    logic [SQ_W-1:0]       r_s1_sqx, r_s1_sqy;

    // stage 2: compare and update
    t_ctl                  r_s2_ctl;
    logic [COORD_BITS-1:0] r_s2_px, r_s2_py;
    logic [IDX_W-1:0]      r_s2_bidx, n_s2_bidx;
    logic [DIST_W-1:0]     r_s2_bd, n_s2_bd;
    logic [DIST_W-1:0]     dist_sq;
    logic                  take;

    assign load_hit = i_ctl.valid && (i_ctl.is_cls == REQ_LOAD)
                      && (32'(i_ctl.slot) == K);
    assign dx = (r_cx >= i_px) ? (r_cx - i_px) : (i_px - r_cx);
    assign dy = (r_cy >= i_py) ? (r_cy - i_py) : (i_py - r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
        end else begin
            if (load_hit) begin
                r_cx <= i_px;
                r_cy <= i_py;
            end
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_px   <= i_px;
        r_s1_py   <= i_py;
        r_s1_bidx <= i_best_idx;
        r_s1_bd   <= i_best_d;
        r_s1_sqx  <= SQ_W'(dx) * SQ_W'(dx);
        r_s1_sqy  <= SQ_W'(dy) * SQ_W'(dy);
        r_s2_px   <= r_s1_px;
        r_s2_py   <= r_s1_py;
        r_s2_bidx <= n_s2_bidx;
        r_s2_bd   <= n_s2_bd;
    end

    assign dist_sq = DIST_W'(r_s1_sqx) + DIST_W'(r_s1_sqy);

    // the first cell always seeds the best; later cells need a strict win
    always_comb begin
        take = r_s1_ctl.is_cls && (32'(i_active) > K)
               && ((K == 0) || (dist_sq < r_s1_bd));
        n_s2_bidx = r_s1_bidx;
        n_s2_bd   = r_s1_bd;
        if (take) begin
            n_s2_bidx = IDX_W'(K);
            n_s2_bd   = dist_sq;
        end
    end

    assign o_ctl      = r_s2_ctl;
    assign o_px       = r_s2_px;
    assign o_py       = r_s2_py;
    assign o_best_idx = r_s2_bidx;
    assign o_best_d   = r_s2_bd;

endmodule

/* sv/nca_checker.sv */
// Port-level checker for nearest_center_assign, bound to the top level.
// Depends on nca_pkg and nearest_center_assign_assert.svh.
`include "nearest_center_assign_assert.svh"

module nca_checker #(
    parameter int MAX_CENTERS = nca_pkg::DEF_MAX_CENTERS
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input nca_pkg::t_req i_req,
    input logic          o_strobe,
    input nca_pkg::t_res o_result
);
    import nca_pkg::*;

    localparam int LAT = 2 * MAX_CENTERS + 1;

    // every accepted request comes out as a strobe after the cell chain and output register
    `NCA_ASSERT_IMPL(a_latency, i_clk, i_rst_n, start && !busy, ##LAT o_strobe)

    // a result carries the kind of the request that caused it
    `NCA_ASSERT_IMPL(a_kind, i_clk, i_rst_n, o_strobe,
                     (o_result.found == $past(i_req.req_type, LAT)))

    // load acknowledgements carry zeros
    `NCA_ASSERT_IMPL(a_ack_zero, i_clk, i_rst_n, o_strobe && !o_result.found,
                     (o_result.nearest_slot == '0) && (o_result.nearest_dist_sq == '0))

    // ready in the cycle after reset ends
    `NCA_ASSERT_NEXT(a_ready, i_clk, i_rst_n, $rose(i_rst_n), !busy)

endmodule

bind nearest_center_assign nca_checker #(
    .MAX_CENTERS (MAX_CENTERS)
) u_nca_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
